### rtl/core/lrp_pkg.sv
`timescale 1ns / 1ps
package lrp_pkg;

  localparam int NumStatesDef     = 64;
  localparam int NumSymbolsDef    = 128;
  localparam int NumRulesDef      = 64;
  localparam int StackDepthDef    = 256;
  localparam int MaxRuleLengthDef = 16;
  localparam int MaxReductionsDef = 64;

  localparam int StateW  = 6;
  localparam int SymbolW = 7;
  localparam int FuncW   = 2;
  localparam int KindW   = 2;
  localparam int RLenW   = 5;
  localparam int StatusW = 3;
  localparam int RedW    = 7;
  localparam int DepthW  = 9;

  localparam logic [FuncW-1:0] FUNC_WR_TABLE = 2'd0;
  localparam logic [FuncW-1:0] FUNC_WR_RULE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_PARSE    = 2'd2;
  localparam logic [FuncW-1:0] FUNC_RESTART  = 2'd3;

  localparam logic [KindW-1:0] K_ERROR  = 2'd0;
  localparam logic [KindW-1:0] K_SHIFT  = 2'd1;
  localparam logic [KindW-1:0] K_REDUCE = 2'd2;
  localparam logic [KindW-1:0] K_ACCEPT = 2'd3;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_ACCEPT    = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_ACTION = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_GOTO   = 3'd3;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [StatusW-1:0] ST_LIMIT     = 3'd5;
  localparam logic [StatusW-1:0] ST_IGNORED   = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic tbl_write;   // write action table
    logic rule_write;  // write rule table
    logic restart;     // reset stack to start state
    logic clr_write;   // write one cleared row entry
    logic rd_top;      // read stack top
    logic rd_act;      // look up action for top/token
    logic rd_rule;     // read rule
    logic pop;         // pop rule length, read new top
    logic rd_goto;     // look up goto
    logic push_tgt;    // push action target
    logic push_goto;   // push goto target
    logic red_inc;     // count a reduction
    logic empty_stack; // clear stack pointer
  } lrp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             clr_done;
    logic             sp_zero;
    logic             full;
    logic [KindW-1:0] act_kind;
    logic             red_limit;
    logic             pop_all;
    logic             goto_shift;
  } lrp_sts_t;

endpackage

### rtl/core/lr_table_driven_parser.sv
`timescale 1ns / 1ps
// channel  | ports                                  | transfer
// in       | in_valid/in_ready, in_func..in_rule_length | valid & ready
// out      | out_valid/out_ready, out_status, out_reductions_done, out_stack_depth | valid & ready
// cfg      | cfg_we, cfg_start_state                | cfg_we
// Writes, restart and ignored tokens go from the execute state to the output transfer.
// A parse token reads the stack top and the action, and per reduction the rule, a pop and
// the goto, all sequenced by the controller around the single-port action table read.
// After reset a clearing pass zeroes all NUM_STATES*NUM_SYMBOLS (8192) action
// table entries; in_ready stays low until it ends.
// One item at a time; a stalled output holds the next input off.
module lr_table_driven_parser import lrp_pkg::*; #(
  parameter int NUM_STATES      = NumStatesDef,
  parameter int NUM_SYMBOLS     = NumSymbolsDef,
  parameter int NUM_RULES       = NumRulesDef,
  parameter int STACK_DEPTH     = StackDepthDef,
  parameter int MAX_RULE_LENGTH = MaxRuleLengthDef,
  parameter int MAX_REDUCTIONS  = MaxReductionsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [StateW-1:0]  cfg_start_state,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FuncW-1:0]   in_func,
  input  logic [StateW-1:0]  in_state_index,
  input  logic [SymbolW-1:0] in_symbol,
  input  logic [KindW-1:0]   in_action_kind,
  input  logic [StateW-1:0]  in_action_target,
  input  logic [StateW-1:0]  in_rule_index,
  input  logic [SymbolW-1:0] in_rule_lhs,
  input  logic [RLenW-1:0]   in_rule_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] out_status,
  output logic [RedW-1:0]    out_reductions_done,
  output logic [DepthW-1:0]  out_stack_depth
);

  logic [StateW-1:0] start_state_r;
  lrp_cmd_t          cmd;
  lrp_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= StateW'(1);
    end else if (cfg_we) begin
      start_state_r <= cfg_start_state;
    end
  end

  lrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (out_status),
    .cmd       (cmd),
    .sts       (sts)
  );

  lrp_datapath #(
    .NUM_STATES      (NUM_STATES),
    .NUM_SYMBOLS     (NUM_SYMBOLS),
    .NUM_RULES       (NUM_RULES),
    .STACK_DEPTH     (STACK_DEPTH),
    .MAX_RULE_LENGTH (MAX_RULE_LENGTH),
    .MAX_REDUCTIONS  (MAX_REDUCTIONS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .start_state      (start_state_r),
    .in_func          (in_func),
    .in_state_index   (in_state_index),
    .in_symbol        (in_symbol),
    .in_action_kind   (in_action_kind),
    .in_action_target (in_action_target),
    .in_rule_index    (in_rule_index),
    .in_rule_lhs      (in_rule_lhs),
    .in_rule_length   (in_rule_length),
    .red_cnt          (out_reductions_done),
    .sp_out           (out_stack_depth)
  );

endmodule

### rtl/core/lrp_datapath.sv
`timescale 1ns / 1ps
module lrp_datapath import lrp_pkg::*; #(
  parameter int NUM_STATES      = NumStatesDef,
  parameter int NUM_SYMBOLS     = NumSymbolsDef,
  parameter int NUM_RULES       = NumRulesDef,
  parameter int STACK_DEPTH     = StackDepthDef,
  parameter int MAX_RULE_LENGTH = MaxRuleLengthDef,
  parameter int MAX_REDUCTIONS  = MaxReductionsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lrp_cmd_t           cmd,
  output lrp_sts_t           sts,
  input  logic [StateW-1:0]  start_state,
  input  logic [FuncW-1:0]   in_func,
  input  logic [StateW-1:0]  in_state_index,
  input  logic [SymbolW-1:0] in_symbol,
  input  logic [KindW-1:0]   in_action_kind,
  input  logic [StateW-1:0]  in_action_target,
  input  logic [StateW-1:0]  in_rule_index,
  input  logic [SymbolW-1:0] in_rule_lhs,
  input  logic [RLenW-1:0]   in_rule_length,
  output logic [RedW-1:0]    red_cnt,
  output logic [DepthW-1:0]  sp_out
);

  localparam int StIdxW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int SymIdxW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int TblDepth = NUM_STATES * NUM_SYMBOLS;
  localparam int TblAW   = StIdxW + SymIdxW;
  localparam int RuleAW  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int StkAW   = $clog2(STACK_DEPTH);
  localparam int SpW     = StkAW + 1;
  localparam int RedCW   = $clog2(MAX_REDUCTIONS + 1);
  localparam int EntW    = KindW + StateW;

  logic [EntW-1:0]    tbl_mem [TblDepth];
  logic [SymbolW+RLenW-1:0] rule_mem [NUM_RULES];
  logic [StateW-1:0]  stk_mem [STACK_DEPTH];

  logic [FuncW-1:0]   func_r;
  logic [StateW-1:0]  sidx_r, tgt_r, ridx_r;
  logic [SymbolW-1:0] sym_r, rlhs_r;
  logic [KindW-1:0]   kind_r;
  logic [RLenW-1:0]   rlen_r;

  logic [TblAW:0]     clr_addr_r;
  logic [SpW-1:0]     sp_r;
  logic [RedCW-1:0]   red_r;
  logic [StateW-1:0]  top_r;
  logic [EntW-1:0]    ent_r;
  logic               ent_ok_r;
  logic [SymbolW-1:0] lhs_r;
  logic [RLenW-1:0]   len_r;

  logic [StateW-1:0]  push_val;
  logic               do_push;
  logic [TblAW-1:0]   rd_addr;
  logic               rd_ok;
  logic [SymbolW-1:0] rd_sym;
  logic [SpW-1:0]     sp_pop;
  logic [RLenW-1:0]   rlen_sat;
  logic [SpW:0]       len_ext;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      sidx_r <= in_state_index;
      sym_r  <= in_symbol;
      kind_r <= in_action_kind;
      tgt_r  <= in_action_target;
      ridx_r <= in_rule_index;
      rlhs_r <= in_rule_lhs;
      rlen_r <= in_rule_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_write) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign rd_sym  = cmd.rd_goto ? lhs_r : sym_r;
  assign rd_ok   = ({26'd0, top_r} < NUM_STATES) && ({25'd0, rd_sym} < NUM_SYMBOLS);
  assign rd_addr = {top_r[StIdxW-1:0], rd_sym[SymIdxW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.clr_write) begin
      tbl_mem[clr_addr_r[TblAW-1:0]] <= '0;
    end else if (cmd.tbl_write && ({26'd0, sidx_r} < NUM_STATES)
                 && ({25'd0, sym_r} < NUM_SYMBOLS)) begin
      tbl_mem[{sidx_r[StIdxW-1:0], sym_r[SymIdxW-1:0]}] <= {kind_r, tgt_r};
    end
    if (cmd.rd_act || cmd.rd_goto) begin
      ent_r    <= tbl_mem[rd_addr];
      ent_ok_r <= rd_ok;
    end
  end

  assign rlen_sat = ({27'd0, rlen_r} > MAX_RULE_LENGTH) ? RLenW'(MAX_RULE_LENGTH) : rlen_r;

  always_ff @(posedge clk) begin
    if (cmd.rule_write && ({26'd0, ridx_r} < NUM_RULES)) begin
      rule_mem[ridx_r[RuleAW-1:0]] <= {rlhs_r, rlen_sat};
    end
    if (cmd.rd_rule) begin
      if ({26'd0, ent_r[StateW-1:0]} < NUM_RULES) begin
        {lhs_r, len_r} <= rule_mem[ent_r[RuleAW-1:0]];
      end else begin
        lhs_r <= '0;
        len_r <= '0;
      end
    end
  end

  assign do_push  = cmd.restart || ((cmd.push_tgt || cmd.push_goto) && !sts.full);
  assign push_val = cmd.restart ? start_state : ent_r[StateW-1:0];
  assign sp_pop   = sp_r - SpW'(len_r);

  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_mem[cmd.restart ? '0 : sp_r[StkAW-1:0]] <= push_val;
    end
    if (cmd.rd_top) begin
      top_r <= stk_mem[StkAW'(sp_r - 1'b1)];
    end else if (cmd.pop) begin
      top_r <= stk_mem[StkAW'(sp_pop - 1'b1)];
    end else if (do_push) begin
      top_r <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      red_r <= '0;
    end else begin
      if (cmd.load) begin
        red_r <= '0;
      end else if (cmd.red_inc) begin
        red_r <= red_r + 1'b1;
      end
      if (cmd.restart) begin
        sp_r <= SpW'(1);
      end else if (cmd.empty_stack) begin
        sp_r <= '0;
      end else if (cmd.pop) begin
        sp_r <= sp_pop;
      end else if (do_push) begin
        sp_r <= sp_r + 1'b1;
      end
    end
  end

  assign len_ext        = (SpW+1)'(len_r);
  assign sts.func       = func_r;
  assign sts.clr_done   = clr_addr_r[TblAW];
  assign sts.sp_zero    = (sp_r == '0);
  assign sts.full       = (sp_r == SpW'(STACK_DEPTH));
  assign sts.act_kind   = ent_ok_r ? ent_r[EntW-1 -: KindW] : K_ERROR;
  assign sts.red_limit  = (red_r == RedCW'(MAX_REDUCTIONS));
  assign sts.pop_all    = (len_ext >= {1'b0, sp_r});
  assign sts.goto_shift = ent_ok_r && (ent_r[EntW-1 -: KindW] == K_SHIFT);

  assign red_cnt = RedW'(red_r);
  assign sp_out  = DepthW'(sp_r);

endmodule

### rtl/core/lrp_ctrl.sv
`timescale 1ns / 1ps
module lrp_ctrl import lrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] status,
  output lrp_cmd_t           cmd,
  input  lrp_sts_t           sts
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_TOP, S_ACT, S_DECIDE, S_RULE, S_POP,
    S_GOTO, S_GDECIDE, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [StatusW-1:0] status_r, status_nxt;
  logic               finished_r, finished_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign status    = status_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    finished_nxt  = finished_r;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_write = !sts.clr_done;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        unique case (sts.func)
          FUNC_WR_TABLE: cmd.tbl_write  = 1'b1;
          FUNC_WR_RULE:  cmd.rule_write = 1'b1;
          FUNC_RESTART: begin
            cmd.restart  = 1'b1;
            finished_nxt = 1'b0;
          end
          default: begin
            if (finished_r) begin
              status_nxt = ST_IGNORED;
            end else begin
              state_nxt = S_TOP;
            end
          end
        endcase
      end
      S_TOP: begin
        if (sts.sp_zero) begin
          status_nxt = ST_NO_GOTO;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_top = 1'b1;
          state_nxt  = S_ACT;
        end
      end
      S_ACT: begin
        cmd.rd_act = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        unique case (sts.act_kind)
          K_ERROR:  status_nxt = ST_NO_ACTION;
          K_ACCEPT: status_nxt = ST_ACCEPT;
          K_SHIFT: begin
            cmd.push_tgt = 1'b1;
            status_nxt   = sts.full ? ST_OVERFLOW : ST_OK;
          end
          default: begin
            if (sts.red_limit) begin
              status_nxt = ST_LIMIT;
            end else begin
              cmd.rd_rule = 1'b1;
              cmd.red_inc = 1'b1;
              state_nxt   = S_RULE;
            end
          end
        endcase
      end
      S_RULE: begin
        if (sts.pop_all) begin
          cmd.empty_stack = 1'b1;
          status_nxt      = ST_NO_GOTO;
          state_nxt       = S_DONE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_GOTO;
        end
      end
      S_GOTO: begin
        cmd.rd_goto = 1'b1;
        state_nxt   = S_GDECIDE;
      end
      S_GDECIDE: begin
        if (!sts.goto_shift) begin
          status_nxt = ST_NO_GOTO;
          state_nxt  = S_DONE;
        end else if (sts.full) begin
          status_nxt = ST_OVERFLOW;
          state_nxt  = S_DONE;
        end else begin
          cmd.push_goto = 1'b1;
          state_nxt     = S_ACT;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          if (sts.func == FUNC_PARSE && status_r != ST_OK) begin
            finished_nxt = 1'b1;
          end
        end else if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // goto pushed and top known: reuse top for next action lookup
    if (state_r == S_GDECIDE && cmd.push_goto) begin
      cmd.rd_top = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      finished_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

### rtl/core/lrp_checker.sv
`timescale 1ns / 1ps
module lrp_checker import lrp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [StatusW-1:0] out_status,
  input logic [RedW-1:0]    out_reductions_done,
  input logic [DepthW-1:0]  out_stack_depth
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_stack_depth))
    else $error("output changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_IGNORED)
    else $error("status code out of range");

  a_ok_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ACCEPT |-> out_stack_depth != '0)
    else $error("accept on empty stack");

  a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after transfer");

endmodule

bind lr_table_driven_parser lrp_checker u_lrp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_reductions_done (out_reductions_done),
  .out_stack_depth     (out_stack_depth)
);

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lrp_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int StackMax   = 256;
  localparam int RedMax     = 64;
  localparam int RuleLenMax = 16;

  typedef struct {
    logic [FuncW-1:0]   func;
    logic [StateW-1:0]  state_index;
    logic [SymbolW-1:0] symbol;
    logic [KindW-1:0]   action_kind;
    logic [StateW-1:0]  action_target;
    logic [StateW-1:0]  rule_index;
    logic [SymbolW-1:0] rule_lhs;
    logic [RLenW-1:0]   rule_length;
  } parser_item_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [RedW-1:0]    reductions;
    logic [DepthW-1:0]  depth;
  } parse_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [StateW-1:0]  cfg_start_state = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FuncW-1:0]   in_func = '0;
  logic [StateW-1:0]  in_state_index = '0;
  logic [SymbolW-1:0] in_symbol = '0;
  logic [KindW-1:0]   in_action_kind = '0;
  logic [StateW-1:0]  in_action_target = '0;
  logic [StateW-1:0]  in_rule_index = '0;
  logic [SymbolW-1:0] in_rule_lhs = '0;
  logic [RLenW-1:0]   in_rule_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StatusW-1:0] out_status;
  logic [RedW-1:0]    out_reductions_done;
  logic [DepthW-1:0]  out_stack_depth;

  logic [7:0]         action_mem [0:8191];
  logic [SymbolW-1:0] lhs_mem [0:63];
  logic [RLenW-1:0]   len_mem [0:63];
  logic [StateW-1:0]  state_stk [0:StackMax-1];
  int unsigned        depth_q = 0;
  bit                 finished_q = 1'b1;
  logic [StateW-1:0]  start_q = 6'd1;
  int                 written_rules [$];
  parse_result_t      pending_results [$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 quiet = 1'b0;
  int                 stall_left = 0;

  lr_table_driven_parser dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_start_state(cfg_start_state),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_state_index(in_state_index), .in_symbol(in_symbol),
    .in_action_kind(in_action_kind), .in_action_target(in_action_target),
    .in_rule_index(in_rule_index), .in_rule_lhs(in_rule_lhs),
    .in_rule_length(in_rule_length), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_reductions_done(out_reductions_done),
    .out_stack_depth(out_stack_depth)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[lr_table_driven_parser] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    parse_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_reductions_done !== exp_r.reductions) begin
          $error("reductions_done: expected %0d, actual %0d", exp_r.reductions,
                 out_reductions_done);
          errors++;
        end
        if (out_stack_depth !== exp_r.depth) begin
          $error("stack_depth: expected %0d, actual %0d", exp_r.depth, out_stack_depth);
          errors++;
        end
      end
    end
  end

  function automatic logic [StatusW-1:0] run_token(input logic [SymbolW-1:0] tok,
                                                   output int red);
    logic [StatusW-1:0] st;
    logic [7:0]         e;
    logic [7:0]         g;
    int unsigned        len;
    bit                 done;
    st = ST_OK;
    red = 0;
    done = 1'b0;
    while (!done) begin
      if (depth_q == 0) begin
        st = ST_NO_GOTO;
        done = 1'b1;
      end else begin
        e = action_mem[{state_stk[depth_q-1], tok}];
        case (e[7:6])
          K_ERROR: begin
            st = ST_NO_ACTION;
            done = 1'b1;
          end
          K_ACCEPT: begin
            st = ST_ACCEPT;
            done = 1'b1;
          end
          K_SHIFT: begin
            if (depth_q >= StackMax) st = ST_OVERFLOW;
            else begin
              state_stk[depth_q] = e[5:0];
              depth_q++;
            end
            done = 1'b1;
          end
          default: begin
            if (red >= RedMax) begin
              st = ST_LIMIT;
              done = 1'b1;
            end else begin
              len = len_mem[e[5:0]];
              red++;
              if (len >= depth_q) begin
                depth_q = 0;
                st = ST_NO_GOTO;
                done = 1'b1;
              end else begin
                depth_q -= len;
                g = action_mem[{state_stk[depth_q-1], lhs_mem[e[5:0]]}];
                if (g[7:6] != K_SHIFT) begin
                  st = ST_NO_GOTO;
                  done = 1'b1;
                end else if (depth_q >= StackMax) begin
                  st = ST_OVERFLOW;
                  done = 1'b1;
                end else begin
                  state_stk[depth_q] = g[5:0];
                  depth_q++;
                end
              end
            end
          end
        endcase
      end
    end
    return st;
  endfunction

  function automatic parse_result_t predict_item(input parser_item_t it);
    parse_result_t r;
    int            red;
    r.status = ST_OK;
    r.reductions = '0;
    case (it.func)
      FUNC_WR_TABLE: action_mem[{it.state_index, it.symbol}] = {it.action_kind,
                                                                 it.action_target};
      FUNC_WR_RULE: begin
        lhs_mem[it.rule_index] = it.rule_lhs;
        len_mem[it.rule_index] = (it.rule_length > RuleLenMax) ? RLenW'(RuleLenMax)
                                                                : it.rule_length;
      end
      FUNC_PARSE: begin
        if (finished_q) r.status = ST_IGNORED;
        else begin
          r.status = run_token(it.symbol, red);
          r.reductions = RedW'(red);
          if (r.status != ST_OK) finished_q = 1'b1;
        end
      end
      default: begin
        state_stk[0] = start_q;
        depth_q = 1;
        finished_q = 1'b0;
      end
    endcase
    r.depth = DepthW'(depth_q);
    return r;
  endfunction

  task automatic send_item(input parser_item_t it);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_func <= it.func;
    in_state_index <= it.state_index;
    in_symbol <= it.symbol;
    in_action_kind <= it.action_kind;
    in_action_target <= it.action_target;
    in_rule_index <= it.rule_index;
    in_rule_lhs <= it.rule_lhs;
    in_rule_length <= it.rule_length;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, predict_item(it)};
    if (it.func == FUNC_WR_RULE && !(it.rule_index inside {written_rules}))
      written_rules = {written_rules, int'(it.rule_index)};
  endtask

  function automatic parser_item_t noise_fields(input logic [FuncW-1:0] f);
    parser_item_t it;
    it.func = f;
    it.state_index = StateW'($urandom);
    it.symbol = SymbolW'($urandom);
    it.action_kind = KindW'($urandom);
    it.action_target = StateW'($urandom);
    it.rule_index = StateW'($urandom);
    it.rule_lhs = SymbolW'($urandom);
    it.rule_length = RLenW'($urandom_range(0, RuleLenMax));
    return it;
  endfunction

  task automatic put_entry(input int s, input int sym, input logic [KindW-1:0] k,
                           input int tgt);
    parser_item_t it;
    it = noise_fields(FUNC_WR_TABLE);
    it.state_index = StateW'(s);
    it.symbol = SymbolW'(sym);
    it.action_kind = k;
    it.action_target = StateW'(tgt);
    send_item(it);
  endtask

  task automatic put_rule(input int idx, input int lhs, input int len);
    parser_item_t it;
    it = noise_fields(FUNC_WR_RULE);
    it.rule_index = StateW'(idx);
    it.rule_lhs = SymbolW'(lhs);
    it.rule_length = RLenW'(len);
    send_item(it);
  endtask

  task automatic parse_token(input int tok);
    parser_item_t it;
    it = noise_fields(FUNC_PARSE);
    it.symbol = SymbolW'(tok);
    send_item(it);
  endtask

  task automatic restart_parse();
    send_item(noise_fields(FUNC_RESTART));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_start_state(input logic [StateW-1:0] v);
    drain();
    repeat (20) @(negedge clk);
    cfg_start_state <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_q = v;
  endtask

  task automatic test_before_restart();
    parse_token("$");
    restart_parse();
    parse_token("a");
    parse_token("a");
  endtask

  // a then $: shift, reduce to a goto, accept; then limit, pop past bottom,
  // goto of the wrong kind, a saturated rule length and an error action
  task automatic test_small_grammar();
    put_rule(0, 10, 1);
    put_rule(1, 11, 0);
    put_rule(2, 12, 31);
    put_rule(3, 13, 1);
    put_entry(1, "a", K_SHIFT, 2);
    put_entry(2, "$", K_REDUCE, 0);
    put_entry(1, 10, K_SHIFT, 3);
    put_entry(3, "$", K_ACCEPT, 0);
    put_entry(1, "b", K_REDUCE, 1);
    put_entry(1, 11, K_SHIFT, 1);
    put_entry(1, "c", K_REDUCE, 0);
    put_entry(2, "d", K_REDUCE, 3);
    put_entry(2, "e", K_REDUCE, 2);
    restart_parse();
    parse_token("a");
    parse_token("$");
    restart_parse();
    parse_token("b");
    restart_parse();
    parse_token("c");
    parse_token("a");
    restart_parse();
    parse_token("a");
    parse_token("d");
    restart_parse();
    parse_token("a");
    parse_token("e");
    put_entry(3, "$", K_ERROR, 0);
    restart_parse();
    parse_token("a");
    parse_token("$");
  endtask

  task automatic test_field_extremes();
    set_start_state(6'd0);
    put_entry(0, 0, K_ACCEPT, 63);
    put_rule(63, 127, 16);
    restart_parse();
    parse_token(0);
  endtask

  task automatic test_stack_overflow();
    set_start_state(6'd63);
    put_entry(63, 127, K_SHIFT, 63);
    restart_parse();
    repeat (StackMax) parse_token(127);
    parse_token(127);
  endtask

  task automatic random_table_write(input bit narrow);
    parser_item_t it;
    int           pick;
    it = noise_fields(FUNC_WR_TABLE);
    if (narrow) begin
      it.state_index = StateW'($urandom_range(0, 5));
      it.symbol = SymbolW'($urandom_range(0, 5));
      pick = $urandom_range(0, 19);
      it.action_kind = (pick < 8) ? K_SHIFT : (pick < 15) ? K_REDUCE :
                       (pick < 17) ? K_ACCEPT : K_ERROR;
      it.action_target = StateW'($urandom_range(0, (it.action_kind == K_REDUCE) ? 7 : 5));
    end else if (it.action_kind == K_REDUCE) begin
      it.action_target = StateW'(written_rules[$urandom_range(0, written_rules.size()-1)]);
    end
    send_item(it);
  endtask

  task automatic test_random_grammars();
    for (int r = 0; r < 8; r++) put_rule(r, $urandom_range(0, 5), $urandom_range(0, 2));
    for (int s = 0; s < 26; s++) begin
      if (s == 23) quiet = 1'b1;
      if (s % 4 == 0)
        set_start_state(($urandom_range(0, 4) == 0) ? StateW'($urandom)
                                                    : StateW'($urandom_range(0, 5)));
      if (s == 12) drain();
      repeat ($urandom_range(4, 10)) random_table_write(1'b1);
      if ($urandom_range(0, 1)) begin
        put_rule($urandom_range(0, 7), $urandom_range(0, 5),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, RuleLenMax)
                                             : $urandom_range(0, 2));
      end
      restart_parse();
      repeat ($urandom_range(8, 16)) begin
        case ($urandom_range(0, 19))
          0: random_table_write(1'b0);
          1: put_rule($urandom_range(8, 63), $urandom_range(0, 127),
                      $urandom_range(0, RuleLenMax));
          2: restart_parse();
          3: parse_token($urandom_range(0, 127));
          default: parse_token($urandom_range(0, 5));
        endcase
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8192; i++) action_mem[i] = '0;
    for (int i = 0; i < 64; i++) begin
      lhs_mem[i] = '0;
      len_mem[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_before_restart();
    test_small_grammar();
    test_field_extremes();
    test_stack_overflow();
    test_random_grammars();
    drain();
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[lr_table_driven_parser] OK");
    end else begin
      $display("[lr_table_driven_parser] ERROR");
    end
    $finish;
  end

endmodule
